### design/kfpv_pkg.sv
// Shared types, constants and the micro-program of the position/velocity Kalman filter.
package kfpv_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] MAX32 = 32'h7fff_ffff;
  localparam logic [31:0] MIN32 = 32'h8000_0000;
  localparam int PC_W = 6;

  typedef enum logic [1:0] {
    MODE_PREDICT = 2'd0,
    MODE_UPDATE  = 2'd1,
    MODE_REINIT  = 2'd2,
    MODE_INVALID = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL2,
    ST_DIVW,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_SHR,
    OP_DIV,
    OP_CHK,
    OP_END
  } op_t;

  typedef enum logic [4:0] {
    R_X0, R_X1, R_P00, R_P01, R_P10, R_P11,
    R_T0, R_T1, R_T2, R_T3, R_T4, R_T5,
    R_DT, R_Q, R_Z, R_R, R_ONE, R_ZERO
  } reg_t;

  typedef struct packed {
    op_t  op;
    reg_t a;
    reg_t b;
    reg_t dst;
  } uop_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [30:0]        time_step;
    logic signed [31:0] measured_position;
    logic [30:0]        measurement_variance;
    logic signed [31:0] load_position;
    logic signed [31:0] load_velocity;
  } kfpv_in_t;

  typedef struct packed {
    logic signed [31:0] position_est;
    logic signed [31:0] velocity_est;
    logic signed [31:0] cov_pp;
    logic signed [31:0] cov_pv;
    logic signed [31:0] cov_vp;
    logic signed [31:0] cov_vv;
    logic               singular_flag;
    logic               saturated_flag;
  } kfpv_out_t;

  localparam logic [PC_W-1:0] PC_PREDICT = PC_W'(0);
  localparam logic [PC_W-1:0] PC_UPDATE  = PC_W'(23);

  // Clip a wide signed value to 32 bits
  function automatic logic [31:0] clip64(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > $signed({32'd0, MAX32})) begin
      r = MAX32;
    end else if (v < $signed({32'hffff_ffff, MIN32})) begin
      r = MIN32;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic ovf64(input logic signed [63:0] v);
    return (v > $signed({32'd0, MAX32})) || (v < $signed({32'hffff_ffff, MIN32}));
  endfunction

  // Predict runs from PC_PREDICT, update from PC_UPDATE
  function automatic uop_t uop(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = '{OP_MUL, R_DT,  R_X1,   R_T0};
      6'd1:  u = '{OP_ADD, R_X0,  R_T0,   R_X0};
      6'd2:  u = '{OP_MUL, R_DT,  R_P10,  R_T0};
      6'd3:  u = '{OP_ADD, R_P00, R_T0,   R_T1};
      6'd4:  u = '{OP_MUL, R_DT,  R_P11,  R_T0};
      6'd5:  u = '{OP_ADD, R_P01, R_T0,   R_T2};
      6'd6:  u = '{OP_MUL, R_T2,  R_DT,   R_T0};
      6'd7:  u = '{OP_ADD, R_T1,  R_T0,   R_T3};
      6'd8:  u = '{OP_MUL, R_P11, R_DT,   R_T0};
      6'd9:  u = '{OP_ADD, R_P10, R_T0,   R_T4};
      6'd10: u = '{OP_MUL, R_DT,  R_DT,   R_T5};
      6'd11: u = '{OP_SHR, R_T5,  R_ZERO, R_T1};
      6'd12: u = '{OP_MUL, R_T1,  R_T1,   R_T0};
      6'd13: u = '{OP_MUL, R_T0,  R_Q,    R_T0};
      6'd14: u = '{OP_ADD, R_T3,  R_T0,   R_P00};
      6'd15: u = '{OP_MUL, R_T1,  R_DT,   R_T1};
      6'd16: u = '{OP_MUL, R_T1,  R_Q,    R_T0};
      6'd17: u = '{OP_ADD, R_T2,  R_T0,   R_P01};
      6'd18: u = '{OP_MUL, R_T1,  R_Q,    R_T0};
      6'd19: u = '{OP_ADD, R_T4,  R_T0,   R_P10};
      6'd20: u = '{OP_MUL, R_T5,  R_Q,    R_T0};
      6'd21: u = '{OP_ADD, R_P11, R_T0,   R_P11};
      6'd22: u = '{OP_END, R_ZERO, R_ZERO, R_T0};
      6'd23: u = '{OP_SUB, R_Z,   R_X0,   R_T0};
      6'd24: u = '{OP_ADD, R_P00, R_R,    R_T1};
      6'd25: u = '{OP_CHK, R_T1,  R_ZERO, R_T1};
      6'd26: u = '{OP_DIV, R_P00, R_T1,   R_T2};
      6'd27: u = '{OP_DIV, R_P10, R_T1,   R_T3};
      6'd28: u = '{OP_MUL, R_T2,  R_T0,   R_T4};
      6'd29: u = '{OP_ADD, R_X0,  R_T4,   R_X0};
      6'd30: u = '{OP_MUL, R_T3,  R_T0,   R_T4};
      6'd31: u = '{OP_ADD, R_X1,  R_T4,   R_X1};
      6'd32: u = '{OP_SUB, R_ONE, R_T2,   R_T2};
      6'd33: u = '{OP_SUB, R_ZERO, R_T3,  R_T3};
      6'd34: u = '{OP_MUL, R_T3,  R_P01,  R_T4};
      6'd35: u = '{OP_ADD, R_T4,  R_P11,  R_P11};
      6'd36: u = '{OP_MUL, R_T3,  R_P00,  R_T4};
      6'd37: u = '{OP_ADD, R_T4,  R_P10,  R_P10};
      6'd38: u = '{OP_MUL, R_T2,  R_P01,  R_P01};
      6'd39: u = '{OP_MUL, R_T2,  R_P00,  R_P00};
      default: u = '{OP_END, R_ZERO, R_ZERO, R_T0};
    endcase
    return u;
  endfunction

endpackage

### design/kfpv_div.sv
// Restoring radix-2 divider: (num << FRAC_BITS) / den, truncated toward zero, saturated.
module kfpv_div
  import kfpv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo,
  output logic        ovf
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd;
  logic [NW-1:0] qm;
  logic [31:0]   rem;
  logic [31:0]   dsr;
  logic          neg;
  logic [CW-1:0] cnt;
  logic          busy;

  logic [32:0]   rem_sh;
  logic          fits;
  logic [31:0]   num_abs;
  logic [31:0]   den_abs;

  assign num_abs = num[31] ? (32'd0 - num) : num;
  assign den_abs = den[31] ? (32'd0 - den) : den;
  assign rem_sh  = {rem, dvd[NW-1]};
  assign fits    = rem_sh >= {1'b0, dsr};

  // Load operands, then retire one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        dvd  <= {num_abs, {FRAC_BITS{1'b0}}};
        qm   <= '0;
        rem  <= '0;
        dsr  <= den_abs;
        neg  <= num[31] ^ den[31];
      end else if (busy) begin
        dvd <= {dvd[NW-2:0], 1'b0};
        qm  <= {qm[NW-2:0], fits};
        rem <= fits ? 32'(rem_sh - {1'b0, dsr}) : rem_sh[31:0];
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply sign and clip the magnitude
  always_comb begin
    if (neg) begin
      ovf = qm > NW'({1'b1, 31'd0});
      quo = ovf ? MIN32 : (32'd0 - qm[31:0]);
    end else begin
      ovf = qm > NW'(MAX32);
      quo = ovf ? MAX32 : qm[31:0];
    end
  end

endmodule

### design/kalman_filter_pos_vel.sv
// Top level: two-state Kalman filter sequenced over one multiplier, one adder and a divider.
//
//  channel | signals                      | payload
//  --------+------------------------------+------------------------------
//  req     | req_valid / req_ready        | kfpv_in_t (mode, dt, z, R, loads)
//  rsp     | rsp_valid / rsp_ready        | kfpv_out_t (state, P, flags)
//  cfg     | cfg_we                       | cfg_data = acceleration noise variance
//
// An update is dominated by two 48-step divisions and ends at the check when S is zero;
// reinitialize and unknown modes go straight to the result register.
// A multiply passes EXEC and MUL2 on the single 32x32 multiplier, an add or subtract
// only EXEC on the shared adder. Reset is synchronous: state zero, covariance identity,
// acceleration noise 1.0. req_ready is high only while the sequencer is idle, from the
// cycle after a result is loaded; the sequencer holds while the output register is full.
module kalman_filter_pos_vel
  import kfpv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  kfpv_in_t    req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output kfpv_out_t   rsp,
  input  logic        cfg_we,
  input  logic [30:0] cfg_data
);

  state_t state, state_next;
  logic [PC_W-1:0] pc, pc_next;

  logic [31:0] x0, x1, p00, p01, p10, p11;
  logic [31:0] t0, t1, t2, t3, t4, t5;
  logic [30:0] dt, rv, accel_noise;
  logic [31:0] z;
  logic signed [63:0] prod;
  logic        sat, singular;

  uop_t        u;
  logic [31:0] opa, opb;
  logic signed [63:0] sum_w, mul_sh;
  logic        wr_en, sat_set, sing_set, div_start, rsp_load;
  logic [31:0] wr_val;
  logic        div_done, div_ovf;
  logic [31:0] div_quo;
  logic        accept;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == ST_IDLE);
  assign u         = uop(pc);

  // Operand select
  function automatic logic [31:0] rd(input reg_t r);
    logic [31:0] v;
    unique case (r)
      R_X0:   v = x0;
      R_X1:   v = x1;
      R_P00:  v = p00;
      R_P01:  v = p01;
      R_P10:  v = p10;
      R_P11:  v = p11;
      R_T0:   v = t0;
      R_T1:   v = t1;
      R_T2:   v = t2;
      R_T3:   v = t3;
      R_T4:   v = t4;
      R_T5:   v = t5;
      R_DT:   v = {1'b0, dt};
      R_Q:    v = {1'b0, accel_noise};
      R_Z:    v = z;
      R_R:    v = {1'b0, rv};
      R_ONE:  v = ONE_FX;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  assign opa    = rd(u.a);
  assign opb    = rd(u.b);
  assign sum_w  = (u.op == OP_SUB)
                ? ($signed({{32{opa[31]}}, opa}) - $signed({{32{opb[31]}}, opb}))
                : ($signed({{32{opa[31]}}, opa}) + $signed({{32{opb[31]}}, opb}));
  assign mul_sh = prod >>> FRAC_BITS;

  kfpv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (opa),
    .den   (opb),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  // Decode the current micro-op and advance
  always_comb begin
    state_next = state;
    pc_next    = pc;
    wr_en      = 1'b0;
    wr_val     = 32'd0;
    sat_set    = 1'b0;
    sing_set   = 1'b0;
    div_start  = 1'b0;
    rsp_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.mode == MODE_PREDICT) begin
            pc_next    = PC_PREDICT;
            state_next = ST_EXEC;
          end else if (req.mode == MODE_UPDATE) begin
            pc_next    = PC_UPDATE;
            state_next = ST_EXEC;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_EXEC: begin
        unique case (u.op)
          OP_MUL: state_next = ST_MUL2;
          OP_ADD, OP_SUB: begin
            wr_en   = 1'b1;
            wr_val  = clip64(sum_w);
            sat_set = ovf64(sum_w);
            pc_next = pc + PC_W'(1);
          end
          OP_SHR: begin
            wr_en   = 1'b1;
            wr_val  = {1'b0, opa[31:1]};
            pc_next = pc + PC_W'(1);
          end
          OP_DIV: begin
            div_start  = 1'b1;
            state_next = ST_DIVW;
          end
          OP_CHK: begin
            if (opa == 32'd0) begin
              sing_set   = 1'b1;
              state_next = ST_DONE;
            end else begin
              pc_next = pc + PC_W'(1);
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_MUL2: begin
        wr_en      = 1'b1;
        wr_val     = clip64(mul_sh);
        sat_set    = ovf64(mul_sh);
        pc_next    = pc + PC_W'(1);
        state_next = ST_EXEC;
      end
      ST_DIVW: begin
        if (div_done) begin
          wr_en      = 1'b1;
          wr_val     = div_quo;
          sat_set    = div_ovf;
          pc_next    = pc + PC_W'(1);
          state_next = ST_EXEC;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Filter state, config register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      x0          <= 32'd0;
      x1          <= 32'd0;
      p00         <= ONE_FX;
      p01         <= 32'd0;
      p10         <= 32'd0;
      p11         <= ONE_FX;
      accel_noise <= ONE_FX[30:0];
      rsp_valid   <= 1'b0;
      sat         <= 1'b0;
      singular    <= 1'b0;
    end else begin
      if (cfg_we) begin
        accel_noise <= cfg_data;
      end
      if (accept) begin
        dt       <= req.time_step;
        z        <= req.measured_position;
        rv       <= req.measurement_variance;
        sat      <= 1'b0;
        singular <= 1'b0;
        if (req.mode == MODE_REINIT) begin
          x0  <= req.load_position;
          x1  <= req.load_velocity;
          p00 <= ONE_FX;
          p01 <= 32'd0;
          p10 <= 32'd0;
          p11 <= ONE_FX;
        end
      end
      if (sat_set) begin
        sat <= 1'b1;
      end
      if (sing_set) begin
        singular <= 1'b1;
      end
      if (state == ST_EXEC && u.op == OP_MUL) begin
        prod <= $signed(opa) * $signed(opb);
      end
      if (wr_en) begin
        unique case (u.dst)
          R_X0:  x0  <= wr_val;
          R_X1:  x1  <= wr_val;
          R_P00: p00 <= wr_val;
          R_P01: p01 <= wr_val;
          R_P10: p10 <= wr_val;
          R_P11: p11 <= wr_val;
          R_T0:  t0  <= wr_val;
          R_T1:  t1  <= wr_val;
          R_T2:  t2  <= wr_val;
          R_T3:  t3  <= wr_val;
          R_T4:  t4  <= wr_val;
          R_T5:  t5  <= wr_val;
          default: ;
        endcase
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Capture the result transaction
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.position_est   <= x0;
      rsp.velocity_est   <= x1;
      rsp.cov_pp         <= p00;
      rsp.cov_pv         <= p01;
      rsp.cov_vp         <= p10;
      rsp.cov_vv         <= p11;
      rsp.singular_flag  <= singular;
      rsp.saturated_flag <= sat;
    end
  end

endmodule

### design/kfpv_checker.sv
// Port-level checks for the Kalman filter top level, bound to it.
module kfpv_checker
  import kfpv_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input kfpv_out_t rsp
);

  // Drop ready right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req_ready high right after an accepted transaction");

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed or dropped");

  // Come out of reset idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("not idle after reset");

  // A new result only follows a busy cycle
  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result appeared without work");

endmodule

bind kalman_filter_pos_vel kfpv_checker u_kfpv_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
